// File: src/cta_pkg.sv
// Shared types, constants and helper functions for the codon-to-amino-acid translator.
// No dependencies; every other file refers to it by scoped names.
package cta_pkg;

   localparam int TableWords  = 5;
   localparam int WordBits    = 64;
   localparam int EntryBits   = 5;
   localparam int CodonBits   = 6;
   localparam int TableBits   = TableWords * WordBits;
   localparam int AddrBits    = 6;
   localparam int RegIdxBits  = 3;

   // register indexes (byte address = 8 * index)
   localparam logic [RegIdxBits-1:0] RegReverse = 3'd0;
   localparam logic [RegIdxBits-1:0] RegTable0  = 3'd1;
   localparam logic [RegIdxBits-1:0] RegTable1  = 3'd2;
   localparam logic [RegIdxBits-1:0] RegTable2  = 3'd3;
   localparam logic [RegIdxBits-1:0] RegTable3  = 3'd4;
   localparam logic [RegIdxBits-1:0] RegTable4  = 3'd5;

   localparam logic [7:0]           AmbigResidue = 8'h58;   // 'X'
   localparam logic [CodonBits-1:0] CodonMask    = 6'h3F;

   typedef struct packed {
      logic                 reverse;
      logic [TableBits-1:0] table_flat;   // entry i at bits 5i+4:5i
   } cfg_type;

   typedef struct packed {
      logic       ambig;
      logic [1:0] code;
   } base_code_type;

   // one result in flight between the codon stage and the lookup stage
   typedef struct packed {
      logic [CodonBits-1:0] codon;
      logic                 force_x;    // ambiguous base or partial codon
      logic                 last;
   } codon_word_type;

   function automatic base_code_type base_decode(input logic [7:0] ch);
      base_code_type r;
      r.ambig = 1'b0;
      r.code  = 2'd0;
      unique case (ch)
         8'h41, 8'h61: r.code = 2'd0;   // A a
         8'h43, 8'h63: r.code = 2'd1;   // C c
         8'h47, 8'h67: r.code = 2'd2;   // G g
         8'h54, 8'h74: r.code = 2'd3;   // T t
         default:      r.ambig = 1'b1;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] residue_letter(input logic [EntryBits-1:0] code);
      logic [7:0] r;
      unique case (code)
         5'd0:    r = 8'h41;  // A
         5'd1:    r = 8'h43;  // C
         5'd2:    r = 8'h44;  // D
         5'd3:    r = 8'h45;  // E
         5'd4:    r = 8'h46;  // F
         5'd5:    r = 8'h47;  // G
         5'd6:    r = 8'h48;  // H
         5'd7:    r = 8'h49;  // I
         5'd8:    r = 8'h4B;  // K
         5'd9:    r = 8'h4C;  // L
         5'd10:   r = 8'h4D;  // M
         5'd11:   r = 8'h4E;  // N
         5'd12:   r = 8'h50;  // P
         5'd13:   r = 8'h51;  // Q
         5'd14:   r = 8'h52;  // R
         5'd15:   r = 8'h53;  // S
         5'd16:   r = 8'h54;  // T
         5'd17:   r = 8'h56;  // V
         5'd18:   r = 8'h57;  // W
         5'd19:   r = 8'h59;  // Y
         5'd20:   r = 8'h2A;  // stop
         default: r = AmbigResidue;
      endcase
      return r;
   endfunction

endpackage

// File: src/cta_csr.sv
// Configuration register file: strand select and the packed 64-entry code table.
// Uses cta_pkg for register indexes and the cfg_type bundle.
module cta_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [cta_pkg::AddrBits-1:0] csr_paddr,
   input  logic [63:0]                  csr_pwdata,
   output logic [63:0]                  csr_prdata,
   output logic                         csr_pready,
   output cta_pkg::cfg_type             cfg
);

   logic                                  reverse_ff, reverse_in;
   logic [cta_pkg::TableWords-1:0][63:0]  table_ff, table_in;
   logic [cta_pkg::RegIdxBits-1:0]        reg_idx;
   logic                                  wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[cta_pkg::AddrBits-1:3];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      reverse_in = reverse_ff;
      table_in   = table_ff;
      if (wr_en) begin
         unique case (reg_idx)
            cta_pkg::RegReverse: reverse_in  = csr_pwdata[0];
            cta_pkg::RegTable0:  table_in[0] = csr_pwdata;
            cta_pkg::RegTable1:  table_in[1] = csr_pwdata;
            cta_pkg::RegTable2:  table_in[2] = csr_pwdata;
            cta_pkg::RegTable3:  table_in[3] = csr_pwdata;
            cta_pkg::RegTable4:  table_in[4] = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         cta_pkg::RegReverse: csr_prdata = {63'd0, reverse_ff};
         cta_pkg::RegTable0:  csr_prdata = table_ff[0];
         cta_pkg::RegTable1:  csr_prdata = table_ff[1];
         cta_pkg::RegTable2:  csr_prdata = table_ff[2];
         cta_pkg::RegTable3:  csr_prdata = table_ff[3];
         cta_pkg::RegTable4:  csr_prdata = table_ff[4];
         default:             csr_prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_ff <= 1'b0;
         table_ff   <= '0;
      end else begin
         reverse_ff <= reverse_in;
         table_ff   <= table_in;
      end
   end

   assign cfg.reverse    = reverse_ff;
   assign cfg.table_flat = table_ff;

endmodule

// File: src/cta_codon.sv
// Codon assembly stage: decodes each base, collects three into a codon and registers
// one codon word per result. Uses cta_pkg for base decoding and the codon_word_type.
module cta_codon (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,
   input  logic                    req_tlast,
   input  logic                    lookup_ready,
   output logic                    word_valid,
   output cta_pkg::codon_word_type word
);

   logic [3:0]              partial_ff, partial_in;
   logic [1:0]              held_ff, held_in;
   logic                    ambig_ff, ambig_in;
   logic                    valid_ff, valid_in;
   cta_pkg::codon_word_type word_ff, word_in;
   cta_pkg::base_code_type  bc;
   logic                    accept;
   logic                    ambig_now;
   logic                    complete;
   logic                    emit;

   assign req_tready = !valid_ff || lookup_ready;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      bc        = cta_pkg::base_decode(req_tdata);
      ambig_now = ambig_ff | bc.ambig;
      complete  = (held_ff == 2'd2);
      emit      = complete | req_tlast;

      word_in.codon   = {partial_ff, bc.code};
      word_in.force_x = ambig_now | !complete;
      word_in.last    = req_tlast;

      partial_in = partial_ff;
      held_in    = held_ff;
      ambig_in   = ambig_ff;
      if (accept) begin
         if (emit) begin
            partial_in = 4'd0;
            held_in    = 2'd0;
            ambig_in   = 1'b0;
         end else begin
            // at most one base held here, so the upper code bits are still zero
            partial_in = {partial_ff[1:0], bc.code};
            held_in    = held_ff + 2'd1;
            ambig_in   = ambig_now;
         end
      end

      if (accept)
         valid_in = emit;
      else if (lookup_ready)
         valid_in = 1'b0;
      else
         valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= 4'd0;
         held_ff    <= 2'd0;
         ambig_ff   <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         partial_ff <= partial_in;
         held_ff    <= held_in;
         ambig_ff   <= ambig_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit)
         word_ff <= word_in;
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

// File: src/cta_lookup.sv
// Code table lookup and result register: optional strand complement, 5-bit entry
// select from the packed table, letter decode. Uses cta_pkg for types and the letter map.
module cta_lookup (
   input  logic                    clock,
   input  logic                    reset,
   input  cta_pkg::cfg_type        cfg,
   input  logic                    word_valid,
   input  cta_pkg::codon_word_type word,
   output logic                    lookup_ready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic                    rsp_tlast
);

   localparam int IdxBits = $clog2(cta_pkg::TableBits);

   logic [cta_pkg::CodonBits-1:0] codon;
   logic [IdxBits-1:0]            bit_idx;
   logic [cta_pkg::EntryBits-1:0] entry;
   logic [7:0]                    residue_in, residue_ff;
   logic                          last_ff;
   logic                          valid_ff, valid_in;
   logic                          take;

   assign lookup_ready = !valid_ff || rsp_tready;
   assign take         = word_valid & lookup_ready;

   always_comb begin
      codon   = cfg.reverse ? (word.codon ^ cta_pkg::CodonMask) : word.codon;
      bit_idx = IdxBits'(codon) * IdxBits'(cta_pkg::EntryBits);
      entry   = cfg.table_flat[bit_idx +: cta_pkg::EntryBits];
      residue_in = word.force_x ? cta_pkg::AmbigResidue : cta_pkg::residue_letter(entry);

      if (take)
         valid_in = 1'b1;
      else if (rsp_tready)
         valid_in = 1'b0;
      else
         valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         residue_ff <= residue_in;
         last_ff    <= word.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = residue_ff;
   assign rsp_tlast  = last_ff;

endmodule

// File: src/codon_to_amino_acid_translator.sv
// Top level of the codon-to-amino-acid translator.
// Instantiates cta_csr, cta_codon and cta_lookup; types and constants from cta_pkg.
//
// One ASCII base word is taken per clock while req_tready is high (A/C/G/T in either
// case, anything else is ambiguous). Every third base yields one amino-acid letter; a
// region that ends with one or two bases left gives a final 'X', and a codon holding an
// ambiguous base gives 'X'. tlast on the result follows tlast of the base that closed it.
// A result passes through the codon register, then the table lookup and the result
// register. Each stage holds its word until the next takes it, so the sustained rate
// is one base per cycle whenever rsp_tready is high. Registers (64-bit, byte address
// 8*i): 0 strand select (bit 0, 1 = complement each base), 1..5 the packed code table,
// entry i at bits 5i+4:5i, codes 0..20 index ACDEFGHIKLMNPQRSTVWY*, others give X.
// Reset clears all registers, so every clean codon translates to 'A' until loaded.
// Write configuration only while the stream is idle.
module codon_to_amino_acid_translator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] base
   input  logic                         req_tlast,   // last_base
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,   // [7:0] residue
   output logic                         rsp_tlast,   // last_residue
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [cta_pkg::AddrBits-1:0] csr_paddr,
   input  logic [63:0]                  csr_pwdata,
   output logic [63:0]                  csr_prdata,
   output logic                         csr_pready
);

   cta_pkg::cfg_type        cfg;
   cta_pkg::codon_word_type word;
   logic                    word_valid;
   logic                    lookup_ready;

   cta_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cta_codon u_codon (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .lookup_ready (lookup_ready),
      .word_valid   (word_valid),
      .word         (word)
   );

   cta_lookup u_lookup (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .word_valid   (word_valid),
      .word         (word),
      .lookup_ready (lookup_ready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

// File: verif/codon_to_amino_acid_translator_tb.sv
// Self-checking testbench for codon_to_amino_acid_translator: streams bases, predicts residues
// in-line and compares each result word. Depends on cta_pkg and the translator RTL only.
module codon_to_amino_acid_translator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LongHoldCycles = 300;
   localparam int DrainCycles    = 6;
   localparam int PhaseItems     = 250;

   // receiver stall patterns
   localparam int StallNone     = 0;
   localparam int StallRandom   = 1;
   localparam int StallPeriodic = 2;

   localparam string ResidueLetters = "ACDEFGHIKLMNPQRSTVWY*";
   // standard code, codons in A,C,G,T order with the first base most significant
   localparam string StandardCode =
      "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV*Y*YSSSS*CWCLFLF";

   typedef struct packed {
      logic [7:0] residue;
      logic       last;
   } residue_word_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [7:0]                   req_tdata = 8'h00;   // [7:0] base
   logic                         req_tlast = 1'b0;    // last_base
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [7:0]                   rsp_tdata;           // [7:0] residue
   logic                         rsp_tlast;           // last_residue
   logic                         csr_psel = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite = 1'b0;
   logic [cta_pkg::AddrBits-1:0] csr_paddr = '0;
   logic [63:0]                  csr_pwdata = '0;
   logic [63:0]                  csr_prdata;
   logic                         csr_pready;

   // translation state mirrored in the testbench
   logic                            strand_rev = 1'b0;
   logic [cta_pkg::TableBits-1:0]   table_flat = '0;
   logic [cta_pkg::CodonBits-1:0]   codon_acc = '0;
   logic [1:0]                      bases_in = 2'd0;
   logic                            ambig_seen = 1'b0;

   residue_word_type pending_residues[$];
   int               mismatch_count = 0;
   int               burst_left = 0;
   bit               hold_request = 1'b0;

   codon_to_amino_acid_translator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [7:0] residue_of(input logic [4:0] code);
      if (code > 5'd20)
         return cta_pkg::AmbigResidue;
      return ResidueLetters[code];
   endfunction

   function automatic logic [4:0] code_of(input byte letter);
      for (int i = 0; i < 21; i++)
         if (ResidueLetters[i] == letter)
            return 5'(i);
      return 5'd31;
   endfunction

   function automatic logic [cta_pkg::TableBits-1:0] standard_table();
      logic [cta_pkg::TableBits-1:0] t;
      t = '0;
      for (int i = 0; i < 64; i++)
         t[5*i +: 5] = code_of(StandardCode[i]);
      return t;
   endfunction

   function automatic logic [cta_pkg::TableBits-1:0] random_table(input bit valid_only);
      logic [cta_pkg::TableBits-1:0] t;
      t = '0;
      for (int i = 0; i < 64; i++)
         t[5*i +: 5] = valid_only ? 5'($urandom_range(20)) : 5'($urandom_range(31));
      return t;
   endfunction

   function automatic logic [7:0] random_base();
      logic [7:0] b;
      if ($urandom_range(99) < 82) begin
         case ($urandom_range(7))
            0: b = "A";
            1: b = "C";
            2: b = "G";
            3: b = "T";
            4: b = "a";
            5: b = "c";
            6: b = "g";
            default: b = "t";
         endcase
      end else begin
         b = 8'($urandom_range(255));
      end
      return b;
   endfunction

   // advance the codon state by one accepted base; queue the residue it completes
   task automatic translate_base(input logic [7:0] b, input logic l);
      logic [1:0]                    code;
      logic                          ambig;
      logic [cta_pkg::CodonBits-1:0] codon;
      residue_word_type              w;
      ambig = 1'b0;
      code  = 2'd0;
      case (b)
         "A", "a": code = 2'd0;
         "C", "c": code = 2'd1;
         "G", "g": code = 2'd2;
         "T", "t": code = 2'd3;
         default:  ambig = 1'b1;
      endcase
      codon = {codon_acc[3:0], code};
      ambig = ambig | ambig_seen;
      if (bases_in == 2'd2) begin
         if (ambig) begin
            w.residue = cta_pkg::AmbigResidue;
         end else begin
            if (strand_rev)
               codon = codon ^ cta_pkg::CodonMask;
            w.residue = residue_of(table_flat[codon*5 +: 5]);
         end
         w.last = l;
         pending_residues.push_back(w);
         codon_acc  = '0;
         bases_in   = 2'd0;
         ambig_seen = 1'b0;
      end else if (l) begin
         // region ended on a partial codon
         w.residue = cta_pkg::AmbigResidue;
         w.last    = 1'b1;
         pending_residues.push_back(w);
         codon_acc  = '0;
         bases_in   = 2'd0;
         ambig_seen = 1'b0;
      end else begin
         codon_acc  = codon;
         bases_in   = bases_in + 2'd1;
         ambig_seen = ambig;
      end
   endtask

   task automatic send_base(input logic [7:0] b, input logic l);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      translate_base(b, l);
   endtask

   task automatic send_paced(input logic [7:0] b, input logic l);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            req_tdata  <= 8'($urandom);
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      send_base(b, l);
   endtask

   task automatic send_codon(input string s, input logic l);
      for (int i = 0; i < s.len(); i++)
         send_base(s[i], l && (i == s.len() - 1));
   endtask

   // wait for every predicted residue, then let the pipeline settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_residues.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [cta_pkg::RegIdxBits-1:0] idx, input logic [63:0] data);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == cta_pkg::RegReverse)
         strand_rev = data[0];
      else
         table_flat[(idx - cta_pkg::RegTable0) * 64 +: 64] = data;
      @(posedge clock);
   endtask

   task automatic load_table(input logic [cta_pkg::TableBits-1:0] t);
      for (int w = 0; w < cta_pkg::TableWords; w++)
         csr_write(3'(cta_pkg::RegTable0 + w), t[64*w +: 64]);
   endtask

   // reset table is all zero: every clean codon reads 'A'
   task automatic test_reset_table();
      send_codon("ACG", 1'b0);
      send_codon("aT", 1'b0);
      send_base(8'hFF, 1'b1);
      send_base(8'h00, 1'b0);
      send_codon("tt", 1'b0);
      drain();
   endtask

   task automatic test_standard_code();
      csr_write(cta_pkg::RegReverse, 64'd0);
      load_table(standard_table());
      send_codon("ATG", 1'b0);
      send_codon("TAA", 1'b0);
      send_codon("tgg", 1'b1);
      send_codon("GC", 1'b1);
      send_codon("C", 1'b1);
      drain();
   endtask

   task automatic test_reverse_strand();
      csr_write(cta_pkg::RegReverse, 64'hFFFF_FFFF_FFFF_FFFF);
      send_codon("TAC", 1'b0);
      send_codon("ttt", 1'b1);
      drain();
      csr_write(cta_pkg::RegReverse, 64'd0);
   endtask

   // table codes above twenty read as 'X'
   task automatic test_out_of_range_codes();
      logic [cta_pkg::TableBits-1:0] t;
      load_table('1);
      send_codon("GGG", 1'b1);
      drain();
      t = '0;
      for (int i = 0; i < 64; i++)
         t[5*i +: 5] = 5'd21;
      load_table(t);
      send_codon("AAA", 1'b1);
      drain();
   endtask

   // mostly whole codons per region, a share of ragged regions and junk bytes
   task automatic run_regions(input int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(99) < 85) ? 3 * $urandom_range(1, 12) : $urandom_range(1, 20);
         for (int i = 0; i < len; i++)
            send_paced(random_base(), i == len - 1);
         sent += len;
      end
      drain();
   endtask

   task automatic test_random_translation();
      load_table(standard_table());
      run_regions(PhaseItems);
      csr_write(cta_pkg::RegReverse, 64'd1);
      run_regions(PhaseItems);
      load_table(random_table(1'b1));
      run_regions(PhaseItems);
      csr_write(cta_pkg::RegReverse, 64'd0);
      load_table({$urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom});
      run_regions(PhaseItems);
      load_table(random_table(1'b0));
      run_regions(PhaseItems);
   endtask

   // receiver holds off while bases keep coming, so the input side must stall
   task automatic test_backpressure();
      load_table(standard_table());
      hold_request = 1'b1;
      for (int i = 0; i < 81; i++)
         send_base(random_base(), i == 80);
      drain();
   endtask

   initial begin : rx_pattern
      int seg_left;
      int seg_kind;
      int tick;
      seg_left = 0;
      seg_kind = StallNone;
      tick     = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LongHoldCycles - 1) @(posedge clock);
         end else begin
            if (seg_left == 0) begin
               seg_kind = $urandom_range(StallPeriodic);
               seg_left = $urandom_range(1, 40);
            end
            seg_left--;
            case (seg_kind)
               StallNone:   rsp_tready <= 1'b1;
               StallRandom: rsp_tready <= ($urandom_range(99) < 55);
               default:     rsp_tready <= ((tick % 5) < 3);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      residue_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_residues.size() == 0) begin
            $error("unexpected residue word: residue %h last %b", rsp_tdata, rsp_tlast);
            mismatch_count++;
         end else begin
            want = pending_residues.pop_front();
            if (rsp_tdata !== want.residue) begin
               $error("residue: expected %h actual %h", want.residue, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_residue: expected %b actual %b", want.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_table();
      test_standard_code();
      test_reverse_strand();
      test_out_of_range_codes();
      test_random_translation();
      test_backpressure();
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
